// File: rtl/sorted_key_table_macros.svh
// assertion macros for the sorted key table
`ifndef SORTED_KEY_TABLE_MACROS_SVH
`define SORTED_KEY_TABLE_MACROS_SVH

`ifndef SYNTH

// condition holds at every edge out of reset
`define SKT_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("sorted_key_table: invariant violated");

// antecedent at one edge implies consequent at the next
`define SKT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorted_key_table: sequence violated");

`else

`define SKT_ASSERT_ALWAYS(lbl, cond)
`define SKT_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: rtl/skt_pkg.sv
`default_nettype none

package skt_pkg;

  localparam int VAL_W = 17;
  localparam int ACT_W = 2;
  localparam int ST_W  = 3;

  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_FIND   = 2'd2;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd3;

  localparam logic [ST_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [ST_W-1:0] ST_DUPLICATE = 3'd1;
  localparam logic [ST_W-1:0] ST_FULL      = 3'd2;
  localparam logic [ST_W-1:0] ST_REMOVED   = 3'd3;
  localparam logic [ST_W-1:0] ST_NOTFOUND  = 3'd4;
  localparam logic [ST_W-1:0] ST_EMPTY     = 3'd5;
  localparam logic [ST_W-1:0] ST_FOUND     = 3'd6;
  localparam logic [ST_W-1:0] ST_CLEARED   = 3'd7;

  // per-cell control broadcast from the sequencer
  typedef struct packed {
    logic cmp_en;
    logic ins_en;
    logic rem_en;
    logic clr;
  } skt_ctl_t;

  // per-cell compare result, registered in the cell
  typedef struct packed {
    logic above;  // empty or key greater than request key
    logic past;   // valid and key not below request key
    logic eq;     // valid and key equal to request key
  } skt_flags_t;

endpackage

`default_nettype wire

// File: rtl/skt_cell.sv
`default_nettype none

module skt_cell #(
  parameter int KW = 20
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire skt_pkg::skt_ctl_t        ctl,
  input  wire logic [KW-1:0]            req_key,
  input  wire logic [skt_pkg::VAL_W-1:0] req_value,
  input  wire logic [KW-1:0]            lo_key,
  input  wire logic [skt_pkg::VAL_W-1:0] lo_value,
  input  wire logic                     lo_valid,
  input  wire logic                     lo_above,
  input  wire logic [KW-1:0]            hi_key,
  input  wire logic [skt_pkg::VAL_W-1:0] hi_value,
  input  wire logic                     hi_valid,
  output logic [KW-1:0]                 key,
  output logic [skt_pkg::VAL_W-1:0]     value,
  output logic                          valid,
  output skt_pkg::skt_flags_t           flags
);

  logic [KW-1:0]             key_r, key_nxt;
  logic [skt_pkg::VAL_W-1:0] value_r, value_nxt;
  logic                      valid_r, valid_nxt;
  skt_pkg::skt_flags_t       flags_r, flags_nxt;

  always_comb begin
    key_nxt   = key_r;
    value_nxt = value_r;
    valid_nxt = valid_r;
    priority if (ctl.clr) begin
      valid_nxt = 1'b0;
    end else if (ctl.ins_en && flags_r.above) begin
      if (lo_above) begin
        key_nxt   = lo_key;
        value_nxt = lo_value;
        valid_nxt = lo_valid;
      end else begin
        key_nxt   = req_key;
        value_nxt = req_value;
        valid_nxt = 1'b1;
      end
    end else if (ctl.rem_en && flags_r.past) begin
      key_nxt   = hi_key;
      value_nxt = hi_value;
      valid_nxt = hi_valid;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_comb begin
    flags_nxt = flags_r;
    if (ctl.cmp_en) begin
      flags_nxt.above = !valid_r || (key_r > req_key);
      flags_nxt.past  = valid_r && (key_r >= req_key);
      flags_nxt.eq    = valid_r && (key_r == req_key);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      flags_r <= '0;
    end else begin
      valid_r <= valid_nxt;
      flags_r <= flags_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    value_r <= value_nxt;
  end

  assign key   = key_r;
  assign value = value_r;
  assign valid = valid_r;
  assign flags = flags_r;

endmodule

`default_nettype wire

// File: rtl/sorted_key_table.sv
// channel   | handshake                | payload
// ----------+--------------------------+-------------------------------------------
// request   | in_valid / in_ready      | in_action, in_key, in_value
// result    | out_valid / out_ready    | out_status, out_found_value,
//           |                          | out_removed_key, out_entry_count
//
// each request passes the compare state, which registers the compare flags in all
// cells, then the update state, which shifts the chain, updates the count and loads
// the result. a new request is taken on the update edge, while the last one completes.
// reset clears all valid marks and the count at once, no sweep.
// a result not taken by out_ready holds the update cycle until it can leave.

`default_nettype none

`include "sorted_key_table_macros.svh"

module sorted_key_table #(
  parameter int CAPACITY = 64,
  parameter int KEY_BITS = 20
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [skt_pkg::ACT_W-1:0]       in_action,
  input  wire logic [KEY_BITS-1:0]             in_key,
  input  wire logic [skt_pkg::VAL_W-1:0]       in_value,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [skt_pkg::ST_W-1:0]             out_status,
  output logic [skt_pkg::VAL_W-1:0]            out_found_value,
  output logic [KEY_BITS-1:0]                  out_removed_key,
  output logic [$clog2(CAPACITY+1)-1:0]        out_entry_count
);

  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;

  logic [1:0]                state_r, state_nxt;
  logic [skt_pkg::ACT_W-1:0] act_r;
  logic [KEY_BITS-1:0]       key_r;
  logic [skt_pkg::VAL_W-1:0] value_r;
  logic [CW-1:0]             count_r, count_nxt;

  logic                      out_valid_r;
  logic [skt_pkg::ST_W-1:0]  status_r, status_nxt;
  logic [skt_pkg::VAL_W-1:0] fval_r, fval_nxt;
  logic [KEY_BITS-1:0]       rkey_r, rkey_nxt;
  logic [CW-1:0]             ocount_r;

  logic adv, accept;
  logic full, empty, hit, rem_hit;
  logic ins_ok, rem_ok, find_ok, clr_ok;

  skt_pkg::skt_ctl_t   ctl;
  skt_pkg::skt_flags_t flags_v [CAPACITY];

  logic [KEY_BITS-1:0]       cell_key   [CAPACITY];
  logic [skt_pkg::VAL_W-1:0] cell_value [CAPACITY];
  logic [CAPACITY-1:0]       valid_v, above_v, past_v, eq_v, first_v;
  logic [KEY_BITS-1:0]       sel_key;
  logic [skt_pkg::VAL_W-1:0] sel_value;

  // handshake and sequencing
  assign adv      = (state_r == S_UPD) && (!out_valid_r || out_ready);
  assign in_ready = (state_r == S_IDLE) || adv;
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) begin
        state_nxt = S_CMP;
      end
      S_CMP: state_nxt = S_UPD;
      S_UPD: if (adv) begin
        state_nxt = in_valid ? S_CMP : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // chain of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_BITS-1:0]       lo_key, hi_key;
    logic [skt_pkg::VAL_W-1:0] lo_value, hi_value;
    logic                      lo_valid, lo_above, hi_valid;

    if (i == 0) begin : g_lo_end
      assign lo_key   = '0;
      assign lo_value = '0;
      assign lo_valid = 1'b0;
      assign lo_above = 1'b0;
    end else begin : g_lo
      assign lo_key   = cell_key[i-1];
      assign lo_value = cell_value[i-1];
      assign lo_valid = valid_v[i-1];
      assign lo_above = above_v[i-1];
    end

    if (i == CAPACITY - 1) begin : g_hi_end
      assign hi_key   = '0;
      assign hi_value = '0;
      assign hi_valid = 1'b0;
    end else begin : g_hi
      assign hi_key   = cell_key[i+1];
      assign hi_value = cell_value[i+1];
      assign hi_valid = valid_v[i+1];
    end

    skt_cell #(
      .KW (KEY_BITS)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .req_key   (key_r),
      .req_value (value_r),
      .lo_key    (lo_key),
      .lo_value  (lo_value),
      .lo_valid  (lo_valid),
      .lo_above  (lo_above),
      .hi_key    (hi_key),
      .hi_value  (hi_value),
      .hi_valid  (hi_valid),
      .key       (cell_key[i]),
      .value     (cell_value[i]),
      .valid     (valid_v[i]),
      .flags     (flags_v[i])
    );

    assign above_v[i] = flags_v[i].above;
    assign past_v[i]  = flags_v[i].past;
    assign eq_v[i]    = flags_v[i].eq;
    if (i == 0) begin : g_first0
      assign first_v[i] = past_v[i];
    end else begin : g_first
      assign first_v[i] = past_v[i] && !past_v[i-1];
    end
  end

  // entry at the first cell not below the request key
  always_comb begin
    sel_key   = '0;
    sel_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      sel_key   = sel_key   | (cell_key[i]   & {KEY_BITS{first_v[i]}});
      sel_value = sel_value | (cell_value[i] & {skt_pkg::VAL_W{first_v[i]}});
    end
  end

  // result and cell control
  assign full    = (count_r == CW'(CAPACITY));
  assign empty   = (count_r == '0);
  assign hit     = |eq_v;
  assign rem_hit = (key_r == '0) ? valid_v[0] : hit;

  assign ins_ok  = (act_r == skt_pkg::ACT_INSERT) && !hit && !full;
  assign rem_ok  = (act_r == skt_pkg::ACT_REMOVE) && !empty && rem_hit;
  assign find_ok = (act_r == skt_pkg::ACT_FIND) && !empty && hit;
  assign clr_ok  = (act_r == skt_pkg::ACT_CLEAR) && !empty;

  assign ctl.cmp_en = (state_r == S_CMP);
  assign ctl.ins_en = adv && ins_ok;
  assign ctl.rem_en = adv && rem_ok;
  assign ctl.clr    = adv && clr_ok;

  always_comb begin
    status_nxt = skt_pkg::ST_INSERTED;
    priority if (act_r == skt_pkg::ACT_INSERT) begin
      priority if (hit) begin
        status_nxt = skt_pkg::ST_DUPLICATE;
      end else if (full) begin
        status_nxt = skt_pkg::ST_FULL;
      end else begin
        status_nxt = skt_pkg::ST_INSERTED;
      end
    end else if (empty) begin
      status_nxt = skt_pkg::ST_EMPTY;
    end else if (act_r == skt_pkg::ACT_REMOVE) begin
      status_nxt = rem_hit ? skt_pkg::ST_REMOVED : skt_pkg::ST_NOTFOUND;
    end else if (act_r == skt_pkg::ACT_FIND) begin
      status_nxt = hit ? skt_pkg::ST_FOUND : skt_pkg::ST_NOTFOUND;
    end else begin
      status_nxt = skt_pkg::ST_CLEARED;
    end
  end

  assign fval_nxt = (rem_ok || find_ok) ? sel_value : '0;
  assign rkey_nxt = rem_ok ? sel_key : '0;

  always_comb begin
    count_nxt = count_r;
    priority if (ctl.ins_en) begin
      count_nxt = count_r + CW'(1);
    end else if (ctl.rem_en) begin
      count_nxt = count_r - CW'(1);
    end else if (ctl.clr) begin
      count_nxt = '0;
    end else begin
      count_nxt = count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_r   <= in_action;
      key_r   <= in_key;
      value_r <= in_value;
    end
    if (adv) begin
      status_r <= status_nxt;
      fval_r   <= fval_nxt;
      rkey_r   <= rkey_nxt;
      ocount_r <= count_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_found_value = fval_r;
  assign out_removed_key = rkey_r;
  assign out_entry_count = ocount_r;

  `SKT_ASSERT_ALWAYS(a_count_matches_valid, ($countones(valid_v) == int'(count_r)))
  `SKT_ASSERT_ALWAYS(a_valid_packed, ((valid_v & (valid_v + CAPACITY'(1))) == '0))
  `SKT_ASSERT_NEXT(a_insert_grows, ctl.ins_en, (count_r == $past(count_r) + CW'(1)))

endmodule

`default_nettype wire
